// File: rtl/core/mcdr_pkg.sv
// ----------------------------------------------------------------------------
// mcdr_pkg: shared types and constants of the debounce reporter
// Default sizes, register reset value and the per-lane result record.
// ----------------------------------------------------------------------------
package mcdr_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int TIME_BITS_DEF = 32;

  localparam int DEBOUNCE_W = 16;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

  // what one lane found for the current poll
  typedef struct packed {
    logic report;
    logic level;
  } lane_res_t;

endpackage

// File: rtl/core/mcdr_in_if.sv
// ----------------------------------------------------------------------------
// mcdr_in_if: poll channel
// Valid/ready channel carrying a timestamp and one raw level per channel.
// ----------------------------------------------------------------------------
interface mcdr_in_if #(
  parameter int CHANNELS  = mcdr_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = mcdr_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_time;
  logic [CHANNELS-1:0]  raw_levels;

  modport source (output valid, output now_time, output raw_levels, input ready);
  modport sink   (input valid, input now_time, input raw_levels, output ready);
endinterface

// File: rtl/core/mcdr_out_if.sv
// ----------------------------------------------------------------------------
// mcdr_out_if: report channel
// Valid/ready channel carrying the report mask and reported levels.
// ----------------------------------------------------------------------------
interface mcdr_out_if #(
  parameter int CHANNELS = mcdr_pkg::CHANNELS_DEF
);
  logic                valid;
  logic                ready;
  logic [CHANNELS-1:0] report_mask;
  logic [CHANNELS-1:0] reported_levels;

  modport source (output valid, output report_mask, output reported_levels, input ready);
  modport sink   (input valid, input report_mask, input reported_levels, output ready);
endinterface

// File: rtl/core/mcdr_lane.sv
// ----------------------------------------------------------------------------
// mcdr_lane: debounce state of one channel
// Tracks pending and stable level, decides the report bit for each poll.
// ----------------------------------------------------------------------------
module mcdr_lane #(
  parameter int TIME_BITS = mcdr_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_i,
  input  logic                            reading_i,
  input  logic [TIME_BITS-1:0]            now_i,
  input  logic [mcdr_pkg::DEBOUNCE_W-1:0] debounce_i,
  output mcdr_pkg::lane_res_t             res_o
);

  localparam int CW = (TIME_BITS > mcdr_pkg::DEBOUNCE_W) ? TIME_BITS : mcdr_pkg::DEBOUNCE_W;

  logic                 pend_known_r;
  logic                 pend_level_r;
  logic [TIME_BITS-1:0] pend_since_r;
  logic                 stable_known_r;
  logic                 stable_level_r;

  logic                 restart;
  logic                 same_stable;
  logic [TIME_BITS-1:0] elapsed;
  logic [CW-1:0]        elapsed_x;
  logic [CW-1:0]        debounce_x;
  logic                 fire;

  assign restart     = !pend_known_r || (reading_i != pend_level_r);
  assign same_stable = stable_known_r && (reading_i == stable_level_r);
  // modular difference: a backwards jump reads as a long hold
  assign elapsed     = now_i - pend_since_r;
  assign elapsed_x   = CW'(elapsed);
  assign debounce_x  = CW'(debounce_i);
  assign fire        = !restart && !same_stable && (elapsed_x >= debounce_x);

  assign res_o.report = fire;
  assign res_o.level  = fire & reading_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_known_r   <= 1'b0;
      stable_known_r <= 1'b0;
    end else if (step_i) begin
      if (restart) pend_known_r <= 1'b1;
      if (fire) stable_known_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i && restart) begin
      pend_level_r <= reading_i;
      pend_since_r <= now_i;
    end
    if (step_i && fire) begin
      stable_level_r <= reading_i;
    end
  end

endmodule

// File: rtl/core/mcdr_merge.sv
// ----------------------------------------------------------------------------
// mcdr_merge: result merge and output buffer
// Collects the lane bits of a poll into one beat, with a skid entry.
// ----------------------------------------------------------------------------
module mcdr_merge #(
  parameter int CHANNELS = mcdr_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  logic [CHANNELS-1:0] report_i,
  input  logic [CHANNELS-1:0] level_i,
  output logic                ready_o,
  mcdr_out_if.source          out_ch
);

  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  logic [CHANNELS-1:0] main_rep_r, main_rep_nxt;
  logic [CHANNELS-1:0] main_lev_r, main_lev_nxt;
  logic [CHANNELS-1:0] skid_rep_r, skid_rep_nxt;
  logic [CHANNELS-1:0] skid_lev_r, skid_lev_nxt;
  logic                pop;

  assign ready_o                = !skid_valid_r;
  assign pop                    = main_valid_r && out_ch.ready;
  assign out_ch.valid           = main_valid_r;
  assign out_ch.report_mask     = main_rep_r;
  assign out_ch.reported_levels = main_lev_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_rep_nxt   = main_rep_r;
    main_lev_nxt   = main_lev_r;
    skid_rep_nxt   = skid_rep_r;
    skid_lev_nxt   = skid_lev_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        // advance the parked beat
        main_valid_nxt = 1'b1;
        main_rep_nxt   = skid_rep_r;
        main_lev_nxt   = skid_lev_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push_i;
        main_rep_nxt   = report_i;
        main_lev_nxt   = level_i;
      end
    end else if (push_i) begin
      // hold the new beat while the output stalls
      skid_valid_nxt = 1'b1;
      skid_rep_nxt   = report_i;
      skid_lev_nxt   = level_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_rep_r <= main_rep_nxt;
    main_lev_r <= main_lev_nxt;
    skid_rep_r <= skid_rep_nxt;
    skid_lev_r <= skid_lev_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry valid while output register empty");

  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && main_valid_r && !out_ch.ready) |=> (skid_valid_r && main_valid_r))
    else $error("beat lost on output stall");

  a_levels_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r |-> ((main_lev_r & ~main_rep_r) == '0))
    else $error("level bit set for a channel that did not report");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!main_valid_r && !skid_valid_r))
    else $error("output buffer not empty after reset");

endmodule

// File: rtl/core/multi_channel_debounce_reporter_core.sv
// ----------------------------------------------------------------------------
// multi_channel_debounce_reporter_core: per-channel debounce and change report
// One lane per channel keeps the hold timer; the merge stage emits one beat
// per poll.
// ----------------------------------------------------------------------------
//   port     | dir | handshake        | payload
//   in_ch    | in  | valid/ready      | now_time, raw_levels
//   out_ch   | out | valid/ready      | report_mask, reported_levels
//   cfg_*    | in  | cfg_we, no ready | cfg_wdata = debounce_time
//
// One poll per cycle while in_ch.ready is high; the lane compare/subtract is
// combinational and its result is registered in the output register on out_ch.
// A skid entry lets one more poll in while a result waits; in_ch.ready drops
// only while both output entries are full.
// rst_n is synchronous: lanes forget all levels, debounce_time returns to 20.
// ----------------------------------------------------------------------------
module multi_channel_debounce_reporter_core #(
  parameter int CHANNELS  = mcdr_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = mcdr_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mcdr_in_if.sink                         in_ch,
  mcdr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [mcdr_pkg::DEBOUNCE_W-1:0] cfg_wdata
);

  logic [mcdr_pkg::DEBOUNCE_W-1:0] debounce_r;
  logic                            step;
  logic                            merge_ready;
  logic [CHANNELS-1:0]             lane_rep;
  logic [CHANNELS-1:0]             lane_lev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= mcdr_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = merge_ready;
  assign step        = in_ch.valid && merge_ready;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    mcdr_pkg::lane_res_t res;

    mcdr_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_i    (step),
      .reading_i (in_ch.raw_levels[g]),
      .now_i     (in_ch.now_time),
      .debounce_i(debounce_r),
      .res_o     (res)
    );

    assign lane_rep[g] = res.report;
    assign lane_lev[g] = res.level;
  end

  mcdr_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (step),
    .report_i(lane_rep),
    .level_i (lane_lev),
    .ready_o (merge_ready),
    .out_ch  (out_ch)
  );

endmodule
